FILE: rtl/core/level_meter_ballistics_macros.svh
// ----------------------------------------------------------------------------
// Level meter ballistics: assertion macros
// Concurrent assertion helpers shared by the meter RTL.
// ----------------------------------------------------------------------------
`ifndef LEVEL_METER_BALLISTICS_MACROS_SVH
`define LEVEL_METER_BALLISTICS_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define LMB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define LMB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/lmb_pkg.sv
// ----------------------------------------------------------------------------
// lmb_pkg
// Types and constants for the level meter ballistics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lmb_pkg;

   // Level format: signed Q7.8 dB
   localparam int LEVEL_W   = 16;
   localparam int COEF_W    = 16;
   localparam int HOLD_W    = 11;
   localparam int HOLD_MS_W = 16;

   // dB constants in Q7.8
   localparam logic signed [LEVEL_W-1:0] LEVEL_RESET  = -16'sd25600;  // -100 dB
   localparam logic signed [LEVEL_W-1:0] DRAWN_RESET  = -16'sd32768;
   localparam logic        [LEVEL_W:0]   DB_0P1       = 17'd26;
   localparam logic        [LEVEL_W:0]   DB_0P5       = 17'd128;
   localparam logic signed [LEVEL_W:0]   DB_0P3       = 17'sd77;

   // Smoothing coefficients, unsigned Q0.16
   localparam logic [COEF_W-1:0] COEF_NEAR  = 16'd60293;  // 0.92
   localparam logic [COEF_W-1:0] COEF_MID   = 16'd55706;  // 0.85
   localparam logic [COEF_W-1:0] COEF_RESET = 16'd52429;  // 0.80

   // hold ticks = hold_ms * 20 / 1000 = hold_ms / 50, by reciprocal:
   // floor(x * 83887 / 2^22) is exact for every 16-bit x
   localparam int                 HOLD_RECIP_W = 17;
   localparam logic [HOLD_RECIP_W-1:0] HOLD_RECIP = 17'd83887;
   localparam int                 HOLD_SHIFT   = 22;
   localparam logic [HOLD_MS_W-1:0] HOLD_MS_RESET = 16'd1500;

   // Item kinds
   localparam logic KIND_LEVEL = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   // Register indexes
   localparam logic [1:0] REG_SMOOTHING_COEF   = 2'd0;
   localparam logic [1:0] REG_PEAK_HOLD_ENABLE = 2'd1;
   localparam logic [1:0] REG_HOLD_MS          = 2'd2;

   typedef struct packed {
      logic [COEF_W-1:0]    smoothing_coef;
      logic                 peak_hold_enable;
      logic [HOLD_MS_W-1:0] hold_ms;
   } lmb_cfg_type;

   typedef struct packed {
      logic signed [LEVEL_W-1:0] current_level;
      logic signed [LEVEL_W-1:0] smoothed_level;
      logic signed [LEVEL_W-1:0] peak_level;
      logic        [HOLD_W-1:0]  hold_count;
      logic signed [LEVEL_W-1:0] last_drawn_level;
   } lmb_state_type;

   typedef struct packed {
      logic signed [LEVEL_W-1:0] smoothed_db;
      logic signed [LEVEL_W-1:0] peak_db;
      logic                      redraw;
      logic                      holding;
   } lmb_result_type;

endpackage

FILE: rtl/core/lmb_update.sv
// ----------------------------------------------------------------------------
// lmb_update
// Next-state and result logic for one meter transaction (level or tick).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lmb_update (
   input  logic                                   kind,
   input  logic signed [lmb_pkg::LEVEL_W-1:0]     level_db,
   input  lmb_pkg::lmb_cfg_type                   cfg,
   input  lmb_pkg::lmb_state_type                 state_cur,
   output lmb_pkg::lmb_state_type                 state_nxt,
   output lmb_pkg::lmb_result_type                result
);
   import lmb_pkg::*;

   logic [HOLD_MS_W+HOLD_RECIP_W-1:0] hold_prod;
   logic [HOLD_W-1:0]                 hold_ticks;
   logic signed [LEVEL_W:0]           tgt_diff;      // target - smoothed
   logic        [LEVEL_W:0]           tgt_dist;
   logic        [COEF_W-1:0]          coef;
   logic signed [LEVEL_W:0]           old_diff;      // smoothed - target
   logic signed [2*LEVEL_W+1:0]       prod;
   logic signed [2*LEVEL_W+1:0]       prod_rnd;
   logic signed [2*LEVEL_W+1:0]       step;
   logic signed [LEVEL_W-1:0]         smooth_new;
   logic signed [LEVEL_W:0]           draw_diff;
   logic        [LEVEL_W:0]           draw_dist;
   logic signed [LEVEL_W:0]           decayed;
   logic signed [LEVEL_W:0]           cur_ext;
   logic                              redraw;

   // Hold length in ticks (max 1310, no saturation needed)
   assign hold_prod  = {{HOLD_RECIP_W{1'b0}}, cfg.hold_ms} *
                       {{HOLD_MS_W{1'b0}}, HOLD_RECIP};
   assign hold_ticks = hold_prod[HOLD_SHIFT +: HOLD_W];

   // Coefficient select by distance to target
   assign tgt_diff = {state_cur.current_level[LEVEL_W-1], state_cur.current_level}
                   - {state_cur.smoothed_level[LEVEL_W-1], state_cur.smoothed_level};
   assign tgt_dist = tgt_diff[LEVEL_W] ? (LEVEL_W+1)'(-tgt_diff) : tgt_diff;
   assign coef     = (tgt_dist < DB_0P1) ? COEF_NEAR :
                     (tgt_dist < DB_0P5) ? COEF_MID  : cfg.smoothing_coef;

   // One-pole step: target + round((old - target) * coef / 2^16)
   assign old_diff   = (LEVEL_W+1)'(-tgt_diff);
   assign prod       = (2*LEVEL_W+2)'(old_diff) *
                       (2*LEVEL_W+2)'($signed({1'b0, coef}));
   assign prod_rnd   = prod + (2*LEVEL_W+2)'(32768);
   assign step       = prod_rnd >>> COEF_W;
   assign smooth_new = state_cur.current_level + step[LEVEL_W-1:0];

   // Dead zone against last drawn value
   assign draw_diff = {smooth_new[LEVEL_W-1], smooth_new}
                    - {state_cur.last_drawn_level[LEVEL_W-1], state_cur.last_drawn_level};
   assign draw_dist = draw_diff[LEVEL_W] ? (LEVEL_W+1)'(-draw_diff) : draw_diff;

   // Peak decay, floored at the current level
   assign cur_ext = {state_cur.current_level[LEVEL_W-1], state_cur.current_level};
   assign decayed = {state_cur.peak_level[LEVEL_W-1], state_cur.peak_level} - DB_0P3;

   always_comb begin
      state_nxt = state_cur;
      redraw    = 1'b0;
      if (kind == KIND_LEVEL) begin
         state_nxt.current_level = level_db;
         if (level_db > state_cur.peak_level) begin
            state_nxt.peak_level = level_db;
            state_nxt.hold_count = hold_ticks;
         end
      end else begin
         state_nxt.smoothed_level = smooth_new;
         if (draw_dist > DB_0P1) begin
            state_nxt.last_drawn_level = smooth_new;
            redraw                     = 1'b1;
         end
         if (cfg.peak_hold_enable && (state_cur.hold_count != '0)) begin
            state_nxt.hold_count = state_cur.hold_count - HOLD_W'(1);
         end else if (decayed > cur_ext) begin
            state_nxt.peak_level = decayed[LEVEL_W-1:0];
         end else begin
            state_nxt.peak_level = state_cur.current_level;
         end
      end
   end

   // Result reflects the state after the transaction
   always_comb begin
      result.smoothed_db = state_nxt.smoothed_level;
      result.peak_db     = state_nxt.peak_level;
      result.redraw      = redraw;
      result.holding     = (state_nxt.hold_count != '0);
   end

endmodule

FILE: rtl/core/level_meter_ballistics.sv
// ----------------------------------------------------------------------------
// level_meter_ballistics
// Peak-hold dB meter with level-dependent smoothing, one result per item.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  req     | in        | req_tvalid/req_tready  | tdata level_db, tuser kind
//  rsp     | out       | rsp_tvalid/rsp_tready  | tdata smoothed, peak, redraw, holding
//  csr     | in        | APB, pready tied high  | 3 registers at 0x0, 0x4, 0x8
//
//  One transaction per cycle sustained while rsp_tready is high; an item passes
//  the input register, then update logic into the result register. The path is
//  set by the smoothing multiply plus the dead-zone compare. Synchronous reset
//  loads -100 dB meter levels, a -128 dB last drawn level and register defaults.
//  A stalled result register holds the input register, which then drops req_tready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "level_meter_ballistics_macros.svh"

module level_meter_ballistics (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [15:0] level_db
   input  logic        req_tuser,    // [0] kind
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // [15:0] smoothed_db, [31:16] peak_db,
                                     // [32] redraw, [33] holding, [39:34] zero
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lmb_pkg::*;

   lmb_cfg_type               cfg_ff, cfg_in;
   lmb_state_type             state_ff, state_in;
   lmb_result_type            result;
   lmb_result_type            rsp_ff, rsp_in;
   logic                      in_valid_ff, in_valid_in;
   logic                      in_kind_ff, in_kind_in;
   logic signed [LEVEL_W-1:0] in_level_ff, in_level_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      advance;
   logic                      csr_wr;
   logic [1:0]                csr_idx;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_SMOOTHING_COEF:   cfg_in.smoothing_coef   = csr_pwdata[COEF_W-1:0];
            REG_PEAK_HOLD_ENABLE: cfg_in.peak_hold_enable = csr_pwdata[0];
            REG_HOLD_MS:          cfg_in.hold_ms          = csr_pwdata[HOLD_MS_W-1:0];
            default:              cfg_in                  = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_SMOOTHING_COEF:   csr_prdata = {16'd0, cfg_ff.smoothing_coef};
         REG_PEAK_HOLD_ENABLE: csr_prdata = {31'd0, cfg_ff.peak_hold_enable};
         REG_HOLD_MS:          csr_prdata = {16'd0, cfg_ff.hold_ms};
         default:              csr_prdata = 32'd0;
      endcase
   end

   // Stage control: update runs when the result register can take a result
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_kind_in  = in_kind_ff;
      in_level_in = in_level_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_kind_in  = req_tuser;
         in_level_in = req_tdata;
      end
   end

   lmb_update u_update (
      .kind      (in_kind_ff),
      .level_db  (in_level_ff),
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .result    (result)
   );

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.holding, rsp_ff.redraw,
                        rsp_ff.peak_db, rsp_ff.smoothed_db};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.smoothing_coef   <= COEF_RESET;
         cfg_ff.peak_hold_enable <= 1'b1;
         cfg_ff.hold_ms          <= HOLD_MS_RESET;
         state_ff.current_level    <= LEVEL_RESET;
         state_ff.smoothed_level   <= LEVEL_RESET;
         state_ff.peak_level       <= LEVEL_RESET;
         state_ff.hold_count       <= '0;
         state_ff.last_drawn_level <= DRAWN_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_kind_ff  <= in_kind_in;
      in_level_ff <= in_level_in;
      rsp_ff      <= rsp_in;
   end

   // Checks
   `LMB_ASSERT_NOW(a_peak_not_below_level, clock, reset, 1'b1,
      $signed(state_ff.peak_level) >= $signed(state_ff.current_level),
      "peak fell below current level")
   `LMB_ASSERT_NEXT(a_level_stored, clock, reset, advance && (in_kind_ff == KIND_LEVEL),
      state_ff.current_level == $past(in_level_ff), "level transaction not stored")
   `LMB_ASSERT_NEXT(a_hold_freezes_peak, clock, reset,
      advance && (in_kind_ff == KIND_TICK) && cfg_ff.peak_hold_enable &&
      (state_ff.hold_count != '0),
      $stable(state_ff.peak_level) &&
      (state_ff.hold_count == $past(state_ff.hold_count) - HOLD_W'(1)),
      "peak moved or hold not counted during hold")
   `LMB_ASSERT_NEXT(a_result_follows, clock, reset, advance, rsp_tvalid,
      "update produced no result")

endmodule
